/* rtl/csvt_pkg.sv */
// Package: item types, byte constants and register indexes of the CSV tokenizer.
`default_nettype none
package csvt_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 8;
   localparam int unsigned MAX_RES = 3;
   localparam int unsigned RES_CNT_W = 2;

   localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIELD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RECORD = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_DELIMITER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTE_BYTE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOM_SKIP_ENABLE = 2'd2;

   localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd44;
   localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'd34;

   localparam logic [BYTE_W-1:0] BOM_BYTE0 = 8'hEF;
   localparam logic [BYTE_W-1:0] BOM_BYTE1 = 8'hBB;
   localparam logic [BYTE_W-1:0] BOM_BYTE2 = 8'hBF;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

   localparam logic [1:0] BOM_EXPECT0 = 2'd0;
   localparam logic [1:0] BOM_HELD0 = 2'd1;
   localparam logic [1:0] BOM_HELD1 = 2'd2;
   localparam logic [1:0] BOM_DONE = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              end_of_input;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] out_kind;
      logic [BYTE_W-1:0] out_byte;
      logic              open_quote_at_end;
      logic              last_of_run;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/csv_record_tokenizer.sv */
// Top level: byte-serial CSV tokenizer with BOM skip and a result bundle register.
//
//   channel   ports                           direction   payload
//   req       req_valid req_stall req_item    in          in_byte, end_of_input
//   rsp       rsp_valid rsp_stall rsp_item    out         kind, byte, open quote, last
//   csr       csr_we csr_index csr_wdata      in          write only
//
// An item is tokenized in the cycle it is accepted and its results land in the
// bundle register; they leave one per cycle, so the block takes one item per cycle
// while each item yields at most one result; one with more holds the next until
// its last result leaves. Items without results pass whenever the bundle drains.
// Reset clears the tokenizer state, the bundle and the registers to their defaults.
// A stall on rsp holds the bundle and, through req_stall, the next item.
`default_nettype none
module csv_record_tokenizer
   import csvt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_item,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef struct packed {
      logic in_quote;
      logic quote_pending;
      logic record_started;
   } tok_state_type;

   typedef struct packed {
      tok_state_type st;
      logic          hit;
      rsp_type       res;
   } feed_type;

   function automatic rsp_type make_res(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] b,
                                        logic oq);
      rsp_type r;
      r.out_kind = kind;
      r.out_byte = (kind == KIND_DATA) ? b : '0;
      r.open_quote_at_end = oq;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   function automatic feed_type feed(tok_state_type st, logic [BYTE_W-1:0] b,
                                     logic [BYTE_W-1:0] delim, logic [BYTE_W-1:0] quote);
      feed_type f;
      logic     cont;
      f.st = st;
      f.hit = 1'b0;
      f.res = make_res(KIND_DATA, '0, 1'b0);
      cont = 1'b1;
      if (st.in_quote) begin
         cont = 1'b0;
         if (st.quote_pending) begin
            f.st.quote_pending = 1'b0;
            if (b == quote) begin
               f.hit = 1'b1;
               f.res = make_res(KIND_DATA, b, 1'b0);
            end else begin
               f.st.in_quote = 1'b0;
               cont = 1'b1;
            end
         end else if (b == quote) begin
            f.st.quote_pending = 1'b1;
         end else begin
            f.hit = 1'b1;
            f.res = make_res(KIND_DATA, b, 1'b0);
         end
      end
      if (cont) begin
         if (b == CHAR_CR || b == CHAR_LF) begin
            if (f.st.record_started) begin
               f.hit = 1'b1;
               f.res = make_res(KIND_RECORD, '0, 1'b0);
               f.st.record_started = 1'b0;
            end
         end else begin
            f.st.record_started = 1'b1;
            if (b == quote) begin
               f.st.in_quote = 1'b1;
            end else if (b == delim) begin
               f.hit = 1'b1;
               f.res = make_res(KIND_FIELD, '0, 1'b0);
            end else begin
               f.hit = 1'b1;
               f.res = make_res(KIND_DATA, b, 1'b0);
            end
         end
      end
      return f;
   endfunction

   logic [BYTE_W-1:0]    delim_ff;
   logic [BYTE_W-1:0]    quote_ff;
   logic                 bom_en_ff;
   tok_state_type        st_ff;
   tok_state_type        st_in;
   logic [1:0]           bom_phase_ff;
   logic [1:0]           bom_phase_in;
   logic                 bund_valid_ff;
   logic [RES_CNT_W-1:0] bund_cnt_ff;
   logic [RES_CNT_W-1:0] bund_idx_ff;
   rsp_type              bund_ent_ff [MAX_RES];
   rsp_type              ent_in [MAX_RES];
   logic [RES_CNT_W-1:0] cnt_in;

   logic                 accept;
   logic                 rsp_take;
   logic                 rsp_done;
   logic                 bund_free;
   logic                 bom_match;
   logic                 replay;
   logic                 slot_en [MAX_RES];
   logic [BYTE_W-1:0]    slot_byte [MAX_RES];
   feed_type             slot_f [MAX_RES];
   tok_state_type        eoi_st;
   logic                 slot_hit [MAX_RES];
   rsp_type              slot_res [MAX_RES];

   assign rsp_valid = bund_valid_ff;
   assign rsp_take = bund_valid_ff && !rsp_stall;
   assign rsp_done = rsp_take && (bund_idx_ff == bund_cnt_ff - RES_CNT_W'(1));
   assign bund_free = !bund_valid_ff || rsp_done;
   assign req_stall = !bund_free;
   assign accept = req_valid && !req_stall;

   always_comb begin
      rsp_item = bund_ent_ff[bund_idx_ff];
      rsp_item.last_of_run = (bund_idx_ff == bund_cnt_ff - RES_CNT_W'(1));
   end

   always_comb begin
      bom_match = 1'b0;
      if (bom_en_ff) begin
         case (bom_phase_ff)
            BOM_EXPECT0: bom_match = (req_item.in_byte == BOM_BYTE0);
            BOM_HELD0:   bom_match = (req_item.in_byte == BOM_BYTE1);
            BOM_HELD1:   bom_match = (req_item.in_byte == BOM_BYTE2);
            default:     bom_match = 1'b0;
         endcase
      end
      replay = req_item.end_of_input || (bom_phase_ff != BOM_DONE && !bom_match);

      slot_en[0] = replay && (bom_phase_ff == BOM_HELD0 || bom_phase_ff == BOM_HELD1);
      slot_byte[0] = BOM_BYTE0;
      slot_en[1] = replay && (bom_phase_ff == BOM_HELD1);
      slot_byte[1] = BOM_BYTE1;
      slot_en[2] = !req_item.end_of_input && (bom_phase_ff == BOM_DONE || !bom_match);
      slot_byte[2] = req_item.in_byte;

      slot_f[0] = feed(st_ff, slot_byte[0], delim_ff, quote_ff);
      slot_hit[0] = slot_en[0] && slot_f[0].hit;
      slot_res[0] = slot_f[0].res;
      slot_f[1] = feed(slot_en[0] ? slot_f[0].st : st_ff, slot_byte[1], delim_ff,
                       quote_ff);
      slot_hit[1] = slot_en[1] && slot_f[1].hit;
      slot_res[1] = slot_f[1].res;
      eoi_st = slot_en[1] ? slot_f[1].st : (slot_en[0] ? slot_f[0].st : st_ff);
      slot_f[2] = feed(eoi_st, slot_byte[2], delim_ff, quote_ff);

      if (req_item.end_of_input) begin
         if (eoi_st.quote_pending) begin
            eoi_st.quote_pending = 1'b0;
            eoi_st.in_quote = 1'b0;
         end
         slot_hit[2] = eoi_st.record_started || eoi_st.in_quote;
         slot_res[2] = make_res(KIND_RECORD, '0, eoi_st.in_quote);
         st_in = '0;
         bom_phase_in = BOM_EXPECT0;
      end else begin
         slot_hit[2] = slot_en[2] && slot_f[2].hit;
         slot_res[2] = slot_f[2].res;
         st_in = slot_en[2] ? slot_f[2].st : st_ff;
         if (bom_phase_ff == BOM_DONE || !bom_match) begin
            bom_phase_in = BOM_DONE;
         end else begin
            bom_phase_in = bom_phase_ff + 2'd1;
         end
      end

      cnt_in = '0;
      for (int k = 0; k < MAX_RES; k++) begin
         ent_in[k] = slot_res[k];
      end
      for (int k = 0; k < MAX_RES; k++) begin
         if (slot_hit[k]) begin
            ent_in[cnt_in] = slot_res[k];
            cnt_in = cnt_in + RES_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_RESET;
         quote_ff <= QUOTE_RESET;
         bom_en_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIELD_DELIMITER: delim_ff <= csr_wdata;
            CSR_QUOTE_BYTE:      quote_ff <= csr_wdata;
            CSR_BOM_SKIP_ENABLE: bom_en_ff <= csr_wdata[0];
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
         bom_phase_ff <= BOM_EXPECT0;
         bund_valid_ff <= 1'b0;
         bund_cnt_ff <= '0;
         bund_idx_ff <= '0;
      end else begin
         if (accept) begin
            st_ff <= st_in;
            bom_phase_ff <= bom_phase_in;
         end
         if (accept && cnt_in != '0) begin
            bund_valid_ff <= 1'b1;
            bund_cnt_ff <= cnt_in;
            bund_idx_ff <= '0;
         end else if (rsp_done) begin
            bund_valid_ff <= 1'b0;
         end else if (rsp_take) begin
            bund_idx_ff <= bund_idx_ff + RES_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && cnt_in != '0) begin
         for (int k = 0; k < MAX_RES; k++) begin
            bund_ent_ff[k] <= ent_in[k];
         end
      end
   end

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      bund_valid_ff |-> (bund_cnt_ff != '0) && (bund_idx_ff < bund_cnt_ff))
      else $error("bundle index beyond result count");

   a_pending_in_quote: assert property (@(posedge clock) disable iff (reset)
      st_ff.quote_pending |-> st_ff.in_quote)
      else $error("pending quote outside quotes");

   a_eoi_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.end_of_input |=>
         (st_ff == '0) && (bom_phase_ff == BOM_EXPECT0))
      else $error("state not cleared after end of input");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.out_kind != KIND_DATA) |-> (rsp_item.out_byte == '0))
      else $error("nonzero byte on a field or record end");

endmodule
`default_nettype wire
